// ----- design/rldr_pkg.sv -----
// Shared types, constants and codes for the LED strip running-dot renderer.
package rldr_pkg;

    // Strip and slot sizing
    localparam int LED_COUNT = 1000;
    localparam int MAX_DOTS  = 16;
    localparam int SLOT_W    = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;
    localparam int IDX_W     = $clog2(MAX_DOTS + 1);
    localparam int CNT_W     = $clog2(MAX_DOTS + 1);

    // Fixed-point widths
    localparam int POS_W    = 26;     // Q10.16
    localparam int TRAVEL_W = 40;     // Q8.16 step times 16-bit ms
    localparam int SUM_W    = TRAVEL_W + 1;
    localparam logic [SUM_W-1:0] END_POS = SUM_W'(LED_COUNT) << 16;

    // Command codes
    localparam logic [1:0] CMD_TRIGGER = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_RENDER  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_MS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_RECIP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_BLUE    = 3'd5;

    // Configuration reset values
    localparam logic [23:0] RST_STEP_PER_MS = 24'd1966;
    localparam logic [17:0] RST_DOT_WIDTH   = 18'd7680;
    localparam logic [15:0] RST_WIDTH_RECIP = 16'd2185;
    localparam logic [7:0]  RST_COLOR       = 8'd255;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] elapsed_ms;
        logic [9:0]  pixel_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] active_count;
        logic       dropped;
    } out_item_t;

    typedef struct packed {
        logic [23:0] step_per_ms;
        logic [17:0] dot_width;
        logic [15:0] width_recip;
        logic [7:0]  dot_red;
        logic [7:0]  dot_green;
        logic [7:0]  dot_blue;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] gap;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ----- design/rldr_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rldr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/rldr_cfg_regs.sv -----
// Configuration register file for the running-dot renderer.
module rldr_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rldr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rldr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output rldr_pkg::cfg_t                   cfg
);
    import rldr_pkg::*;

    cfg_t cfg_reg;

    // Register writes; upper data bits beyond a register are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_per_ms <= RST_STEP_PER_MS;
            cfg_reg.dot_width   <= RST_DOT_WIDTH;
            cfg_reg.width_recip <= RST_WIDTH_RECIP;
            cfg_reg.dot_red     <= RST_COLOR;
            cfg_reg.dot_green   <= RST_COLOR;
            cfg_reg.dot_blue    <= RST_COLOR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_PER_MS: cfg_reg.step_per_ms <= cfg_wdata[23:0];
                REG_DOT_WIDTH:   cfg_reg.dot_width   <= cfg_wdata[17:0];
                REG_WIDTH_RECIP: cfg_reg.width_recip <= cfg_wdata[15:0];
                REG_DOT_RED:     cfg_reg.dot_red     <= cfg_wdata[7:0];
                REG_DOT_GREEN:   cfg_reg.dot_green   <= cfg_wdata[7:0];
                REG_DOT_BLUE:    cfg_reg.dot_blue    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/rldr_pix_pipe.sv -----
// Pixel shading pipeline: falloff, color scaling and saturating accumulation.
module rldr_pix_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  rldr_pkg::pix_in_t pix_in,
    input  rldr_pkg::cfg_t    cfg,
    output logic              busy,
    output rldr_pkg::rgb_t    acc
);
    import rldr_pkg::*;

    logic             hit_a_reg, hit_b_reg, hit_c_reg;
    logic [POS_W-1:0] dist_a_reg;
    logic [POS_W-1:0] frac_b_reg;
    rgb_t             contrib_c_reg;
    rgb_t             acc_reg;

    logic [POS_W+15:0] frac_prod;
    logic [16:0]       bright;
    logic [24:0]       prod_r, prod_g, prod_b;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    // Stage b: distance times reciprocal
    assign frac_prod = dist_a_reg * cfg.width_recip;

    // Stage c: brightness and per-channel scaling
    always_comb begin
        if (frac_b_reg[POS_W-1:16] != '0) begin
            bright = 17'd0;
        end else begin
            bright = 17'h10000 - {1'b0, frac_b_reg[15:0]};
        end
        prod_r = cfg.dot_red   * bright;
        prod_g = cfg.dot_green * bright;
        prod_b = cfg.dot_blue  * bright;
    end

    // Stage flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            hit_c_reg <= 1'b0;
        end else begin
            hit_a_reg <= pix_in.hit;
            hit_b_reg <= hit_a_reg;
            hit_c_reg <= hit_b_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        dist_a_reg          <= pix_in.gap;
        frac_b_reg          <= frac_prod[POS_W+15:16];
        contrib_c_reg.red   <= prod_r[23:16];
        contrib_c_reg.green <= prod_g[23:16];
        contrib_c_reg.blue  <= prod_b[23:16];
    end

    // Accumulator, cleared at the start of every item
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            acc_reg <= '0;
        end else if (hit_c_reg) begin
            acc_reg.red   <= sat_add(acc_reg.red,   contrib_c_reg.red);
            acc_reg.green <= sat_add(acc_reg.green, contrib_c_reg.green);
            acc_reg.blue  <= sat_add(acc_reg.blue,  contrib_c_reg.blue);
        end
    end

    assign busy = hit_a_reg | hit_b_reg | hit_c_reg;
    assign acc  = acc_reg;

endmodule

// ----- design/led_strip_running_dot_renderer_top.sv -----
// Top level of the running-dot renderer: slot sequencer around the position RAM.
// Trigger, unused command and zero-time advance go straight to the done state; the result is registered from there.
// Advance: one RAM read per slot, with the write-back in the cycle after the read.
// Render: slot walk plus the four-stage shading pipeline.
// One item at a time; the next item is taken while the previous result waits.
// Synchronous active-low reset empties all slots and restores config defaults.
module led_strip_running_dot_renderer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rldr_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rldr_pkg::out_item_t              m_item,
    input  logic                             cfg_wr_en,
    input  logic [rldr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rldr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rldr_pkg::*;

    cfg_t cfg;

    state_t                state_reg, state_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [TRAVEL_W-1:0]   travel_reg, travel_next;
    logic [9:0]            px_reg, px_next;
    logic                  px_ok_reg, px_ok_next;
    logic                  dropped_reg, dropped_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  p1_vld_reg;
    logic [SLOT_W-1:0]     p1_slot_reg;
    logic [MAX_DOTS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg;
    out_item_t             out_reg;

    logic                  s_acc;
    logic                  out_free;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_slot;
    logic [POS_W-1:0]      rd_data;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [POS_W-1:0]      ram_wdata;
    logic                  slot_live;
    logic [SUM_W-1:0]      adv_sum;
    logic [POS_W-1:0]      px_pos, w_pos, gap;
    pix_in_t               pix_in;
    logic                  pipe_busy;
    rgb_t                  acc;

    rldr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rldr_ram #(.WIDTH(POS_W), .DEPTH(MAX_DOTS)) u_pos_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_slot),
        .rdata (rd_data)
    );

    rldr_pix_pipe u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (s_acc),
        .pix_in  (pix_in),
        .cfg     (cfg),
        .busy    (pipe_busy),
        .acc     (acc)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // First empty slot, lowest index wins
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_DOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Slot walk read side
    assign rd_en   = (state_reg == ST_WALK) && (rd_idx_reg != IDX_W'(MAX_DOTS));
    assign rd_slot = rd_idx_reg[SLOT_W-1:0];

    // Data returned for the slot read last cycle
    assign slot_live = p1_vld_reg && valid_reg[p1_slot_reg];
    assign adv_sum   = {{(SUM_W - POS_W){1'b0}}, rd_data} + {1'b0, travel_reg};
    assign px_pos    = {px_reg, 16'b0};
    assign w_pos     = {cfg.dot_width, 8'b0};
    assign gap       = (px_pos >= rd_data) ? (px_pos - rd_data) : (rd_data - px_pos);

    always_comb begin
        pix_in.hit = slot_live && (cmd_reg == CMD_RENDER) && px_ok_reg && (gap < w_pos);
        pix_in.gap = gap;
    end

    // RAM write: new dot on trigger, write-back of surviving dots on advance.
    // Write-back of slot k lands while slot k+1 is read, so addresses never collide.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p1_slot_reg;
        ram_wdata = adv_sum[POS_W-1:0];
        if (s_acc && (s_item.cmd == CMD_TRIGGER) && free_found) begin
            ram_we    = 1'b1;
            ram_waddr = free_slot;
            ram_wdata = '0;
        end else if (slot_live && (cmd_reg == CMD_ADVANCE) && (adv_sum < END_POS)) begin
            ram_we = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        travel_next  = travel_reg;
        px_next      = px_reg;
        px_ok_next   = px_ok_reg;
        dropped_next = dropped_reg;
        rd_idx_next  = rd_idx_reg;
        valid_next   = valid_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd_next     = s_item.cmd;
                    dropped_next = 1'b0;
                    rd_idx_next  = '0;
                    travel_next  = cfg.step_per_ms * s_item.elapsed_ms;
                    px_next      = s_item.pixel_index;
                    px_ok_next   = (s_item.pixel_index < 10'(LED_COUNT));
                    state_next   = ST_DONE;
                    case (s_item.cmd)
                        CMD_TRIGGER: begin
                            if (free_found) begin
                                valid_next[free_slot] = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_ADVANCE: begin
                            if (s_item.elapsed_ms != '0) begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_RENDER: begin
                            state_next = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                // Dot pushed past the strip end leaves its slot
                if (slot_live && (cmd_reg == CMD_ADVANCE) && (adv_sum >= END_POS)) begin
                    valid_next[p1_slot_reg] = 1'b0;
                    cnt_next = cnt_reg - 1'b1;
                end
                if (!rd_en && !p1_vld_reg && !pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            p1_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
            p1_vld_reg <= rd_en;
            rd_idx_reg <= rd_idx_next;
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        travel_reg  <= travel_next;
        px_reg      <= px_next;
        px_ok_reg   <= px_ok_next;
        dropped_reg <= dropped_next;
        p1_slot_reg <= rd_slot;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            out_reg.red          <= acc.red;
            out_reg.green        <= acc.green;
            out_reg.blue         <= acc.blue;
            out_reg.active_count <= 5'(cnt_reg);
            out_reg.dropped      <= dropped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // Live count tracks the slot flags
    a_cnt_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CNT_W'($countones(valid_reg)))
        else $error("active count out of step with slot flags");

    // Write-back never targets the slot being read
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && rd_en) |-> (ram_waddr != rd_slot))
        else $error("RAM write and read hit the same slot");

    // A drop is reported only with every slot occupied
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.dropped) |-> (out_reg.active_count == 5'(MAX_DOTS)))
        else $error("drop reported with a free slot");

    // Shading pipeline is empty whenever a new item can be taken
    a_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!pipe_busy && !p1_vld_reg))
        else $error("slot walk still in flight while idle");

endmodule

// ----- tb/sv/running_dot_checker.sv -----
// Checker for the running-dot renderer: mirrors slot state and config, predicts and compares.
module running_dot_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  rldr_pkg::in_item_t              s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  rldr_pkg::out_item_t             m_item,
    input  logic                            cfg_wr_en,
    input  logic [rldr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rldr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              open_reports,
    output int                              checked_count,
    output int                              lit_count,
    output int                              drop_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rldr_pkg::*;

    // Mirrored register file
    logic [23:0] rate_q16;
    logic [17:0] halo_q8;
    logic [15:0] halo_inv;
    logic [7:0]  tint_r, tint_g, tint_b;

    // Mirrored dot slots
    logic [POS_W-1:0] dot_at [MAX_DOTS];
    logic             dot_on [MAX_DOTS];

    out_item_t strip_reports_q [$];

    int miss_count = 0;
    int seen_count = 0;
    int lit_seen   = 0;
    int drop_seen  = 0;
    int waiting    = 0;

    assign fail_count    = miss_count;
    assign open_reports  = waiting;
    assign checked_count = seen_count;
    assign lit_count     = lit_seen;
    assign drop_count    = drop_seen;

    // One color channel scaled by a Q1.16 brightness, truncated
    function automatic logic [8:0] shade(logic [7:0] level, logic [16:0] bright);
        logic [24:0] prod;
        prod = 25'(level) * 25'(bright);
        return 9'(prod >> 16);
    endfunction

    // Applies one command to the mirrored strip and returns the expected report
    function automatic out_item_t apply_strip_cmd(in_item_t it);
        out_item_t        res;
        logic [40:0]      travel;
        logic [40:0]      moved;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] reach;
        logic [POS_W-1:0] gap;
        logic [41:0]      frac;
        logic [16:0]      bright;
        logic [8:0]       acc_r, acc_g, acc_b;
        bit               placed;
        int               live;
        res    = '0;
        placed = 1'b0;
        acc_r  = '0;
        acc_g  = '0;
        acc_b  = '0;
        live   = 0;
        case (it.cmd)
            CMD_TRIGGER: begin
                for (int i = 0; i < MAX_DOTS; i++) begin
                    if (!placed && !dot_on[i]) begin
                        dot_on[i] = 1'b1;
                        dot_at[i] = '0;
                        placed    = 1'b1;
                    end
                end
                res.dropped = !placed;
            end
            CMD_ADVANCE: begin
                // exact 40-bit travel; dots reaching the strip end are retired
                if (it.elapsed_ms != '0) begin
                    travel = 41'(rate_q16) * 41'(it.elapsed_ms);
                    for (int i = 0; i < MAX_DOTS; i++) begin
                        if (dot_on[i]) begin
                            moved = 41'(dot_at[i]) + travel;
                            if (moved >= (41'(LED_COUNT) << 16)) begin
                                dot_on[i] = 1'b0;
                                dot_at[i] = '0;
                            end else begin
                                dot_at[i] = POS_W'(moved);
                            end
                        end
                    end
                end
            end
            CMD_RENDER: begin
                if (it.pixel_index < LED_COUNT) begin
                    px    = POS_W'(it.pixel_index) << 16;
                    reach = POS_W'(halo_q8) << 8;
                    for (int i = 0; i < MAX_DOTS; i++) begin
                        if (dot_on[i]) begin
                            gap = (px >= dot_at[i]) ? px - dot_at[i] : dot_at[i] - px;
                            if (gap < reach) begin
                                frac   = (42'(gap) * 42'(halo_inv)) >> 16;
                                bright = (frac >= 42'd65536) ? 17'd0 : 17'(42'd65536 - frac);
                                acc_r  = acc_r + shade(tint_r, bright);
                                acc_g  = acc_g + shade(tint_g, bright);
                                acc_b  = acc_b + shade(tint_b, bright);
                                if (acc_r > 9'd255) acc_r = 9'd255;
                                if (acc_g > 9'd255) acc_g = 9'd255;
                                if (acc_b > 9'd255) acc_b = 9'd255;
                            end
                        end
                    end
                end
                res.red   = acc_r[7:0];
                res.green = acc_g[7:0];
                res.blue  = acc_b[7:0];
            end
            default: ;
        endcase
        for (int i = 0; i < MAX_DOTS; i++) begin
            if (dot_on[i]) live++;
        end
        res.active_count = 5'(live);
        return res;
    endfunction

    // Track config, predict on accepted inputs, compare on accepted results
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            rate_q16 = RST_STEP_PER_MS;
            halo_q8  = RST_DOT_WIDTH;
            halo_inv = RST_WIDTH_RECIP;
            tint_r   = RST_COLOR;
            tint_g   = RST_COLOR;
            tint_b   = RST_COLOR;
            for (int i = 0; i < MAX_DOTS; i++) begin
                dot_at[i] = '0;
                dot_on[i] = 1'b0;
            end
            strip_reports_q.delete();
        end else begin
            // bits above a register's width are dropped by the narrowing
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_PER_MS: rate_q16 = cfg_wdata[23:0];
                    REG_DOT_WIDTH:   halo_q8  = cfg_wdata[17:0];
                    REG_WIDTH_RECIP: halo_inv = cfg_wdata[15:0];
                    REG_DOT_RED:     tint_r   = cfg_wdata[7:0];
                    REG_DOT_GREEN:   tint_g   = cfg_wdata[7:0];
                    REG_DOT_BLUE:    tint_b   = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                strip_reports_q.insert(strip_reports_q.size(), apply_strip_cmd(s_item));
            end
            if (m_valid && m_ready) begin
                if (strip_reports_q.size() == 0) begin
                    if (miss_count < 10) begin
                        $display("%0t: unexpected item r=%0d g=%0d b=%0d count=%0d drop=%0b",
                                 $time, m_item.red, m_item.green, m_item.blue,
                                 m_item.active_count, m_item.dropped);
                    end
                    miss_count++;
                end else begin
                    want = strip_reports_q.pop_front();
                    seen_count++;
                    if (want.red != 0 || want.green != 0 || want.blue != 0) lit_seen++;
                    if (want.dropped) drop_seen++;
                    if (m_item.red !== want.red || m_item.green !== want.green ||
                        m_item.blue !== want.blue ||
                        m_item.active_count !== want.active_count ||
                        m_item.dropped !== want.dropped) begin
                        if (miss_count < 10) begin
                            $display("%0t: mismatch want r=%0d g=%0d b=%0d count=%0d drop=%0b",
                                     $time, want.red, want.green, want.blue,
                                     want.active_count, want.dropped);
                            $display("%0t:           got r=%0d g=%0d b=%0d count=%0d drop=%0b",
                                     $time, m_item.red, m_item.green, m_item.blue,
                                     m_item.active_count, m_item.dropped);
                        end
                        miss_count++;
                    end
                end
            end
        end
        waiting = strip_reports_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top: clock, reset, register setups and command stimulus for the dot renderer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rldr_pkg::*;

    localparam logic [1:0]           CMD_SPARE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI   = 3'd7;
    localparam int                   SETTLE_CYCLES = 30;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count, open_reports, checked_count, lit_count, drop_count;

    bit   lazy_io = 1'b1;
    cfg_t setup;
    int   n_trig = 0, n_adv = 0, n_rend = 0, n_spare = 0, n_setups = 0;

    led_strip_running_dot_renderer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    running_dot_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .open_reports  (open_reports),
        .checked_count (checked_count),
        .lit_count     (lit_count),
        .drop_count    (drop_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side stalls at random unless idling is off
    always @(negedge aclk) begin
        m_ready <= !lazy_io || ($urandom_range(99) >= 18);
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic in_item_t cmd_item(logic [1:0] cmd, logic [15:0] ms, logic [9:0] pix);
        in_item_t it;
        it.cmd         = cmd;
        it.elapsed_ms  = ms;
        it.pixel_index = pix;
        return it;
    endfunction

    // Present one item, holding it until accepted; returns on a falling edge
    task automatic push_item(in_item_t it);
        while (lazy_io && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        case (it.cmd)
            CMD_TRIGGER: n_trig++;
            CMD_ADVANCE: n_adv++;
            CMD_RENDER:  n_rend++;
            default:     n_spare++;
        endcase
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending, let every outstanding report come back, then settle before returning
    task automatic drain();
        s_valid <= 1'b0;
        while (open_reports != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write with random junk above the register's width
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value, int bits);
        logic [23:0] keep;
        keep = (bits >= 24) ? 24'hFFFFFF : ((24'd1 << bits) - 24'd1);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= (value & keep) | (24'($urandom) & ~keep);
        @(negedge aclk);
    endtask

    task automatic load_setup(cfg_t c);
        write_reg(REG_STEP_PER_MS, 24'(c.step_per_ms), $bits(c.step_per_ms));
        write_reg(REG_DOT_WIDTH,   24'(c.dot_width),   $bits(c.dot_width));
        write_reg(REG_WIDTH_RECIP, 24'(c.width_recip), $bits(c.width_recip));
        write_reg(REG_DOT_RED,     24'(c.dot_red),     $bits(c.dot_red));
        write_reg(REG_DOT_GREEN,   24'(c.dot_green),   $bits(c.dot_green));
        write_reg(REG_DOT_BLUE,    24'(c.dot_blue),    $bits(c.dot_blue));
        // a write past the register list must change nothing
        write_reg($urandom_range(1) ? REG_NONE_HI : REG_NONE_LO, 24'($urandom), 24);
        cfg_wr_en <= 1'b0;
        n_setups++;
    endtask

    // Width of a few to tens of pixels with a matching reciprocal
    function automatic cfg_t typical_setup();
        cfg_t c;
        int   r;
        c.dot_width   = 18'($urandom_range(1, 64) * 256 + $urandom_range(0, 255));
        r             = 32'h100_0000 / int'(c.dot_width);
        c.width_recip = (r > 65535) ? 16'hFFFF : 16'(r);
        c.step_per_ms = 24'($urandom_range(64, 24'h3FFFF));
        c.dot_red     = 8'($urandom);
        c.dot_green   = 8'($urandom);
        c.dot_blue    = 8'($urandom);
        return c;
    endfunction

    // Largest elapsed time that keeps one advance near the given travel in pixels
    function automatic int travel_span(logic [23:0] step, int target_px);
        longint s;
        if (step == '0) return 65535;
        s = (longint'(target_px) << 16) / longint'(step);
        if (s < 1) return 1;
        if (s > 65535) return 65535;
        return int'(s);
    endfunction

    // Mostly plausible traffic: triggers, short advances, renders on the strip
    function automatic in_item_t random_item(int emax);
        in_item_t it;
        int       roll;
        it.cmd         = CMD_RENDER;
        it.elapsed_ms  = 16'($urandom);
        it.pixel_index = 10'($urandom);
        roll           = $urandom_range(99);
        if (roll < 18) begin
            it.cmd = CMD_TRIGGER;
        end else if (roll < 40) begin
            it.cmd = CMD_ADVANCE;
            if ($urandom_range(9) != 0) it.elapsed_ms = 16'($urandom_range(1, emax));
            else if ($urandom_range(1) == 0) it.elapsed_ms = '0;
        end else if (roll < 96) begin
            if ($urandom_range(6) != 0) it.pixel_index = 10'($urandom_range(0, LED_COUNT - 1));
        end else begin
            it.cmd = CMD_SPARE;
        end
        return it;
    endfunction

    task automatic run_phase(int count, int target_px);
        int emax;
        emax = travel_span(setup.step_per_ms, target_px);
        repeat (count) push_item(random_item(emax));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        setup.step_per_ms = RST_STEP_PER_MS;
        setup.dot_width   = RST_DOT_WIDTH;
        setup.width_recip = RST_WIDTH_RECIP;
        setup.dot_red     = RST_COLOR;
        setup.dot_green   = RST_COLOR;
        setup.dot_blue    = RST_COLOR;

        // Directed: empty strip, spare command, full slots, falloff edge, strip end
        push_item(cmd_item(CMD_RENDER, 16'hFFFF, 10'd0));
        push_item(cmd_item(CMD_SPARE, 16'hFFFF, 10'h3FF));
        repeat (MAX_DOTS + 1) push_item(cmd_item(CMD_TRIGGER, '0, '0));
        push_item(cmd_item(CMD_RENDER, '0, 10'd0));
        push_item(cmd_item(CMD_RENDER, '0, 10'd29));
        push_item(cmd_item(CMD_RENDER, '0, 10'd30));
        push_item(cmd_item(CMD_ADVANCE, 16'd0, '0));
        push_item(cmd_item(CMD_RENDER, '0, 10'h3FF));
        push_item(cmd_item(CMD_RENDER, '0, 10'(LED_COUNT)));
        push_item(cmd_item(CMD_ADVANCE, 16'hFFFF, '0));
        push_item(cmd_item(CMD_RENDER, '0, 10'(LED_COUNT - 1)));

        // Reset settings
        run_phase(300, 8);
        drain();

        // Everything at its top value: huge steps, reciprocal far too large
        setup = '{24'hFFFFFF, 18'h3FFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
        load_setup(setup);
        run_phase(150, 8);
        drain();

        // Everything zero: dots never move, nothing lights
        setup = '0;
        load_setup(setup);
        run_phase(100, 8);
        drain();

        // Sensible setup with no idling on either side
        lazy_io = 1'b0;
        setup   = typical_setup();
        load_setup(setup);
        run_phase(400, 5);
        drain();
        lazy_io = 1'b1;

        // Widest falloff with zero reciprocal: every dot at full color
        setup             = typical_setup();
        setup.dot_width   = 18'h3FFFF;
        setup.width_recip = '0;
        load_setup(setup);
        run_phase(300, 12);
        drain();

        // Unconstrained register values
        setup.step_per_ms = 24'($urandom_range(0, 24'h7FFFF));
        setup.dot_width   = 18'($urandom);
        setup.width_recip = 16'($urandom);
        setup.dot_red     = 8'($urandom);
        setup.dot_green   = 8'($urandom);
        setup.dot_blue    = 8'($urandom);
        load_setup(setup);
        run_phase(300, $urandom_range(1, 40));
        drain();

        $display("Sent %0d triggers, %0d advances, %0d renders, %0d spare commands; %0d setups.",
                 n_trig, n_adv, n_rend, n_spare, n_setups);
        $display("Checked %0d results: %0d lit pixels, %0d dropped triggers.",
                 checked_count, lit_count, drop_count);
        if (fail_count == 0 && open_reports == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
